[rtl/assert_macros.svh]
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ibbe_pkg.sv]
`default_nettype none

package ibbe_pkg;

    // field widths of the transfers
    localparam int unsigned OPC_W  = 2;
    localparam int unsigned BITS_W = 32;
    localparam int unsigned CNT_W  = 6;
    localparam int unsigned BYTE_W = 8;

    // parameter defaults
    localparam int unsigned QUEUE_DEPTH_DEF = 8;
    localparam int unsigned CODE_WIDTH_DEF  = 32;

    // literal queue never holds more than this, so one item gives at most 16 bytes
    localparam int unsigned QUEUE_LIMIT_MAX = 11;

    // command queue between front and back
    localparam int unsigned CMDQ_DEPTH = 2;

    // opcodes
    localparam logic [OPC_W-1:0] OP_START  = 2'd0;
    localparam logic [OPC_W-1:0] OP_CODE   = 2'd1;
    localparam logic [OPC_W-1:0] OP_FINISH = 2'd2;
    localparam logic [OPC_W-1:0] OP_NONE   = 2'd3;

    // stop code, left-aligned, and its length
    localparam logic [BITS_W-1:0] STOP_CODE = 32'h6010_0000;
    localparam logic [CNT_W-1:0]  STOP_LEN  = 6'd12;

    typedef struct packed {
        logic [OPC_W-1:0]  op;
        logic [BITS_W-1:0] bits;     // left-aligned in 32 bits
        logic [CNT_W-1:0]  n;        // already saturated
        logic              has_lit;
        logic [BYTE_W-1:0] lit;
    } t_cmd;

endpackage

`default_nettype wire

[rtl/interleaved_bit_byte_emitter.sv]
// flow: with the back end idle, a transfer passes the command queue and the load step; a start
//   then leaves from the start step, a filled bit byte from its bit step, a literal sent straight
//   out from the literal step, each via the output register; results leave one per cycle while
//   popped, a closed bit byte before its queued literals (at most QUEUE_DEPTH, capped at 11)
// reset: synchronous, active low; clears the command queue, the bit byte, the literal count and
//   the overflow flag, empties the output register; literal queue contents are left as they are
`default_nettype none

module interleaved_bit_byte_emitter #(
    parameter int unsigned QUEUE_DEPTH = ibbe_pkg::QUEUE_DEPTH_DEF,
    parameter int unsigned CODE_WIDTH  = ibbe_pkg::CODE_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // input side, queue style
    input  wire logic                        push,
    output      logic                        full,
    input  wire logic [ibbe_pkg::OPC_W-1:0]  i_opcode,
    input  wire logic [ibbe_pkg::BITS_W-1:0] i_code_bits,
    input  wire logic [ibbe_pkg::CNT_W-1:0]  i_bit_count,
    input  wire logic                        i_has_literal,
    input  wire logic [ibbe_pkg::BYTE_W-1:0] i_literal,
    // result side, queue style
    output      logic                        empty,
    input  wire logic                        pop,
    output      logic [ibbe_pkg::BYTE_W-1:0] o_out_byte,
    output      logic                        o_last_of_run,
    output      logic                        o_end_of_stream,
    output      logic                        o_overflow
);
    import ibbe_pkg::*;

    // front to queue
    logic  fq_wr;
    t_cmd  fq_cmd;
    // queue to back
    logic  qb_valid;
    t_cmd  qb_cmd;
    logic  qb_pop;

    // front: takes each transfer, aligns the code bits, saturates the count,
    // turns finish into a stop code command and drops the unused opcode
    ibbe_front #(
        .CODE_WIDTH (CODE_WIDTH)
    ) u_front (
        .i_push        (push),
        .i_full        (full),
        .i_opcode      (i_opcode),
        .i_code_bits   (i_code_bits),
        .i_bit_count   (i_bit_count),
        .i_has_literal (i_has_literal),
        .i_literal     (i_literal),
        .o_wr          (fq_wr),
        .o_cmd         (fq_cmd)
    );

    // short command queue so the front keeps taking transfers while the back works
    ibbe_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fq_wr),
        .i_wdata (fq_cmd),
        .o_full  (full),
        .o_valid (qb_valid),
        .o_rdata (qb_cmd),
        .i_rd    (qb_pop)
    );

    // back: packs bits into bit bytes up to a whole byte per cycle, sends each closed bit byte
    // and then the literals queued behind it, one byte per cycle while the output is popped
    ibbe_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (qb_valid),
        .i_cmd           (qb_cmd),
        .o_cmd_pop       (qb_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_out_byte      (o_out_byte),
        .o_last_of_run   (o_last_of_run),
        .o_end_of_stream (o_end_of_stream),
        .o_overflow      (o_overflow)
    );

endmodule

`default_nettype wire

[rtl/ibbe_front.sv]
`default_nettype none

module ibbe_front #(
    parameter int unsigned CODE_WIDTH = ibbe_pkg::CODE_WIDTH_DEF
) (
    input  wire logic                        i_push,
    input  wire logic                        i_full,
    input  wire logic [ibbe_pkg::OPC_W-1:0]  i_opcode,
    input  wire logic [ibbe_pkg::BITS_W-1:0] i_code_bits,
    input  wire logic [ibbe_pkg::CNT_W-1:0]  i_bit_count,
    input  wire logic                        i_has_literal,
    input  wire logic [ibbe_pkg::BYTE_W-1:0] i_literal,
    output      logic                        o_wr,
    output      ibbe_pkg::t_cmd              o_cmd
);
    import ibbe_pkg::*;

    localparam int unsigned AlignSh = BITS_W - CODE_WIDTH;

    logic [BITS_W-1:0] aligned;
    logic [CNT_W-1:0]  n_sat;

    // move the code field up to bit 31 so the back end always takes from the top
    assign aligned = i_code_bits << AlignSh;
    assign n_sat   = (i_bit_count > CNT_W'(CODE_WIDTH)) ? CNT_W'(CODE_WIDTH) : i_bit_count;

    always_comb begin
        o_cmd.op      = i_opcode;
        o_cmd.lit     = i_literal;
        o_cmd.bits    = aligned;
        o_cmd.n       = n_sat;
        o_cmd.has_lit = i_has_literal;
        case (i_opcode)
            OP_START: begin
                o_cmd.n       = '0;
                o_cmd.has_lit = 1'b0;
            end
            OP_FINISH: begin
                o_cmd.bits    = STOP_CODE;
                o_cmd.n       = STOP_LEN;
                o_cmd.has_lit = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // unused opcode is taken but never queued
    assign o_wr = i_push && !i_full && (i_opcode != OP_NONE);

endmodule

`default_nettype wire

[rtl/ibbe_cmdq.sv]
`default_nettype none

module ibbe_cmdq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr,
    input  wire ibbe_pkg::t_cmd i_wdata,
    output      logic           o_full,
    output      logic           o_valid,
    output      ibbe_pkg::t_cmd o_rdata,
    input  wire logic           i_rd
);
    import ibbe_pkg::*;

    `include "assert_macros.svh"

    localparam int unsigned Depth = CMDQ_DEPTH;
    localparam int unsigned PW    = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CW    = $clog2(Depth + 1);

    t_cmd            r_mem [Depth];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_cnt;
    logic            do_rd;

    assign o_full  = (r_cnt == CW'(Depth));
    assign o_valid = (r_cnt != '0);
    assign o_rdata = r_mem[r_rd_ptr];
    assign do_rd   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == PW'(Depth - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PW'(Depth - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_wr && !do_rd) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_wr && do_rd) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    `ASSERT_ALWAYS(a_cmdq_no_write_full, i_clk, i_rst_n, !(i_wr && o_full), "cmd queue written while full")

endmodule

`default_nettype wire

[rtl/ibbe_back.sv]
`default_nettype none

module ibbe_back #(
    parameter int unsigned QUEUE_DEPTH = ibbe_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cmd_valid,
    input  wire ibbe_pkg::t_cmd              i_cmd,
    output      logic                        o_cmd_pop,
    input  wire logic                        i_pop,
    output      logic                        o_empty,
    output      logic [ibbe_pkg::BYTE_W-1:0] o_out_byte,
    output      logic                        o_last_of_run,
    output      logic                        o_end_of_stream,
    output      logic                        o_overflow
);
    import ibbe_pkg::*;

    `include "assert_macros.svh"

    localparam int unsigned Limit = (QUEUE_DEPTH < QUEUE_LIMIT_MAX) ? QUEUE_DEPTH
                                                                    : QUEUE_LIMIT_MAX;
    localparam int unsigned AW = $clog2(Limit);
    localparam int unsigned CW = $clog2(Limit + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_BITS  = 3'd2;
    localparam logic [2:0] S_LIT   = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;

    // sequencer and bit byte state
    logic [2:0]        r_state, n_state;
    logic              r_open, n_open;
    logic [7:0]        r_acc, n_acc;
    logic [2:0]        r_held, n_held;
    logic [CW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_idx, n_idx;
    logic              r_sticky, n_sticky;
    // current item
    logic [BITS_W-1:0] r_bits, n_bits;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic              r_has_lit, n_has_lit;
    logic              r_fin, n_fin;
    logic [BYTE_W-1:0] r_lit, n_lit;
    // literal queue
    logic [BYTE_W-1:0] r_q_mem [Limit];
    logic [BYTE_W-1:0] r_rd_data;
    logic              mem_we;
    // output register
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last, r_out_eos, r_out_ovf;

    logic              can_emit, emit;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_last, emit_eos, emit_ovf;

    logic [3:0]        room, k, held_sum;
    logic [15:0]       wide;
    logic [CNT_W-1:0]  rem_after;
    logic              tail_after, tail_now, idx_last;
    logic [2:0]        pad;

    assign can_emit = !r_out_valid || i_pop;

    // bits that fit into the open bit byte this step
    assign room      = 4'd8 - {1'b0, r_held};
    assign k         = ({2'b0, room} > r_rem) ? r_rem[3:0] : room;
    assign wide      = {r_acc, r_bits[BITS_W-1 -: 8]} << k;
    assign held_sum  = {1'b0, r_held} + k;
    assign rem_after = r_rem - {2'b0, k};
    // no more bytes from this item once fewer than 8 bits remain, unless none remain and a literal follows
    assign tail_after = (rem_after < 6'd8) && !(r_has_lit && rem_after == '0);
    assign tail_now   = (r_rem < 6'd8) && !(r_has_lit && r_rem == '0);
    assign idx_last   = (CW'(r_idx) == r_count - CW'(1));
    // zero padding that closes the bit byte after the stop code
    assign pad        = 3'd4 - r_held;

    always_comb begin
        n_state   = r_state;
        n_open    = r_open;
        n_acc     = r_acc;
        n_held    = r_held;
        n_count   = r_count;
        n_idx     = r_idx;
        n_sticky  = r_sticky;
        n_bits    = r_bits;
        n_rem     = r_rem;
        n_has_lit = r_has_lit;
        n_fin     = r_fin;
        n_lit     = r_lit;
        mem_we    = 1'b0;
        o_cmd_pop = 1'b0;
        emit      = 1'b0;
        emit_byte = r_lit;
        emit_last = 1'b0;
        emit_eos  = 1'b0;
        emit_ovf  = r_sticky;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_bits    = i_cmd.bits;
                    n_lit     = i_cmd.lit;
                    n_has_lit = (i_cmd.op == OP_CODE) && i_cmd.has_lit;
                    n_fin     = (i_cmd.op == OP_FINISH);
                    n_rem     = (i_cmd.op == OP_FINISH) ? STOP_LEN + CNT_W'(pad) : i_cmd.n;
                    n_state   = (i_cmd.op == OP_START) ? S_START : S_BITS;
                end
            end
            S_START: begin
                if (can_emit) begin
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    emit_ovf  = 1'b0;
                    n_open    = 1'b1;
                    n_acc     = '0;
                    n_held    = '0;
                    n_count   = '0;
                    n_sticky  = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            S_BITS: begin
                if (r_rem == '0) begin
                    n_state = S_LIT;
                end else if (held_sum[3]) begin
                    if (can_emit) begin
                        emit      = 1'b1;
                        emit_byte = wide[15:8];
                        emit_last = (r_count == '0) && tail_after;
                        emit_eos  = r_fin && (r_count == '0) && tail_after;
                        n_open    = 1'b0;
                        n_acc     = '0;
                        n_held    = '0;
                        n_rem     = rem_after;
                        n_bits    = r_bits << k;
                        n_idx     = '0;
                        n_state   = (r_count != '0) ? S_DRAIN : S_BITS;
                    end
                end else begin
                    n_open = 1'b1;
                    n_acc  = wide[15:8];
                    n_held = held_sum[2:0];
                    n_rem  = rem_after;
                    n_bits = r_bits << k;
                end
            end
            S_LIT: begin
                if (!r_has_lit) begin
                    n_state = S_IDLE;
                end else if (r_open) begin
                    if (r_count < CW'(Limit)) begin
                        mem_we  = 1'b1;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_sticky = 1'b1;
                    end
                    n_state = S_IDLE;
                end else if (can_emit) begin
                    emit      = 1'b1;
                    emit_last = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_DRAIN: begin
                if (can_emit) begin
                    emit      = 1'b1;
                    emit_byte = r_rd_data;
                    emit_last = idx_last && tail_now;
                    emit_eos  = r_fin && idx_last && tail_now;
                    if (idx_last) begin
                        n_count = '0;
                        n_idx   = '0;
                        n_state = S_BITS;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_open      <= 1'b0;
            r_acc       <= '0;
            r_held      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_sticky    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_open   <= n_open;
            r_acc    <= n_acc;
            r_held   <= n_held;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_sticky <= n_sticky;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits    <= n_bits;
        r_rem     <= n_rem;
        r_has_lit <= n_has_lit;
        r_fin     <= n_fin;
        r_lit     <= n_lit;
        if (emit) begin
            r_out_byte <= emit_byte;
            r_out_last <= emit_last;
            r_out_eos  <= emit_eos;
            r_out_ovf  <= emit_ovf;
        end
    end

    // literal queue, read data registered and addressed with the next index
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_q_mem[r_count[AW-1:0]] <= r_lit;
        end
        r_rd_data <= r_q_mem[n_idx];
    end

    assign o_empty         = !r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_last_of_run   = r_out_last;
    assign o_end_of_stream = r_out_eos;
    assign o_overflow      = r_out_ovf;

    `ASSERT_ALWAYS(a_back_count_limit, i_clk, i_rst_n, r_count <= CW'(Limit), "literal count above limit")
    `ASSERT_ALWAYS(a_back_drain_nonempty, i_clk, i_rst_n, (r_state != S_DRAIN) || (r_count != '0), "drain with empty queue")
    `ASSERT_ALWAYS(a_back_closed_empty, i_clk, i_rst_n, r_open || (r_held == '0), "bits held with no open bit byte")
    `ASSERT_NEXT(a_back_sticky_src, i_clk, i_rst_n, !r_sticky && (r_state != S_LIT), !r_sticky, "overflow flag set outside literal step")

endmodule

`default_nettype wire
